### design/svar_pkg.sv
// Package for the two-pass sample variance block: widths, depth and shared types.
// No dependencies; every module of the block imports it.
package svar_pkg;

  localparam int MaxSamples = 1024;
  localparam int SampleBits = 16;
  localparam int AddrBits = $clog2(MaxSamples);
  localparam int CountBits = AddrBits + 1;
  localparam int SumBits = SampleBits + CountBits;
  // Scaled mean magnitude: |sum| * 2^16.
  localparam int NumBits = SumBits + 16;
  // Difference sample*2^16 - mean.
  localparam int DiffBits = SampleBits + 18;
  localparam int SqBits = 2 * DiffBits;
  localparam int AccBits = SqBits + CountBits;
  // Accumulated total shifted right by 32.
  localparam int TotBits = AccBits - 32;
  localparam int VarBits = 31;
  localparam int OutCountBits = 11;

  // Request to the serial divider.
  typedef struct packed {
    logic                 start;
    logic [TotBits-1:0]   dividend;
    logic [CountBits-1:0] divisor;
  } div_req_t;

  // Divider status back to the sequencer.
  typedef struct packed {
    logic               done;
    logic [TotBits-1:0] quotient;
  } div_rsp_t;

endpackage

### design/svar_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on svar_pkg for widths and the request/response structs.
module svar_div
  import svar_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int StepBits = $clog2(TotBits + 1);

  logic [TotBits-1:0]   quo_r, quo_nxt;
  logic [CountBits:0]   rem_r, rem_nxt;
  logic [CountBits-1:0] dvs_r, dvs_nxt;
  logic [StepBits-1:0]  step_r, step_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CountBits:0]   trial;

  // Shift in one dividend bit, subtract when it fits.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[CountBits-1:0], quo_r[TotBits-1]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      step_nxt = StepBits'(TotBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[TotBits-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[TotBits-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == StepBits'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### design/svar_store.sv
// Sample store: one synchronous memory, one write and one read port.
// Depends on svar_pkg for depth and width.
module svar_store
  import svar_pkg::*;
(
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AddrBits-1:0]   wr_addr,
  input  logic [SampleBits-1:0] wr_data,
  input  logic [AddrBits-1:0]   rd_addr,
  output logic [SampleBits-1:0] rd_data
);

  logic [SampleBits-1:0] mem [MaxSamples];
  logic [SampleBits-1:0] rd_data_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### design/sample_variance_two_pass_top.sv
// Top level of the two-pass sample variance block.
// Depends on svar_pkg, svar_store and svar_div.

// Samples are taken one beat per cycle and written to a 1024-entry memory
// while their sum builds up. A beat with tlast closes the set: the mean is
// formed by a bit-serial division, the memory is then read back once, one
// sample per cycle through registered read, difference and square stages,
// while squared differences are summed, and the total is divided by count
// minus one. No sample is taken until the result beat is accepted. Sets of
// fewer than two samples skip both passes. Samples beyond the store depth
// are dropped and reported in the overflow bit.
module sample_variance_two_pass_top
  import svar_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [30:0] variance, [41:31] sample_count,
                                  // [42] overflow, [47:43] zero
  output logic        out_tlast
);

  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_MEAN  = 7'b0000010,
    ST_MWAIT = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_VAR   = 7'b0010000,
    ST_VWAIT = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [SumBits-1:0]  sum_r, sum_nxt;
  logic [CountBits-1:0]       cnt_r, cnt_nxt;
  logic                       drop_r, drop_nxt;
  logic signed [DiffBits-1:0] mean_r, mean_nxt;
  logic [CountBits-1:0]       rd_cnt_r, rd_cnt_nxt;
  logic                       rd_vld_r, diff_vld_r;
  logic signed [DiffBits-1:0] diff_r;
  logic [SqBits-1:0]          sq_r;
  logic                       sq_vld_r;
  logic [AccBits-1:0]         acc_r, acc_nxt;
  logic [VarBits-1:0]         var_r, var_nxt;

  logic                  in_acc, store_ok;
  logic [SampleBits-1:0] rd_data;
  logic [NumBits-1:0]    num_mag;
  div_req_t              dreq;
  div_rsp_t              drsp;
  logic [DiffBits-1:0]   diff_mag;

  assign in_acc   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_LOAD);
  assign store_ok = (cnt_r < CountBits'(MaxSamples));

  svar_store u_store (
    .clk     (clk),
    .wr_en   (in_acc && store_ok),
    .wr_addr (cnt_r[AddrBits-1:0]),
    .wr_data (in_tdata[SampleBits-1:0]),
    .rd_addr (rd_cnt_r[AddrBits-1:0]),
    .rd_data (rd_data)
  );

  svar_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Magnitude of the sum scaled by 2^16 for the mean division.
  always_comb begin
    logic [SumBits-1:0] mag;
    mag = sum_r[SumBits-1] ? SumBits'(-sum_r) : SumBits'(sum_r);
    num_mag = {mag, 16'h0000};
  end

  // Divider requests: mean first, then variance.
  always_comb begin
    dreq = '0;
    if (state_r == ST_MEAN) begin
      dreq.start    = 1'b1;
      dreq.dividend = TotBits'(num_mag);
      dreq.divisor  = cnt_r;
    end else if (state_r == ST_VAR) begin
      dreq.start    = 1'b1;
      dreq.dividend = acc_r[AccBits-1:32];
      dreq.divisor  = cnt_r - 1'b1;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    drop_nxt   = drop_r;
    mean_nxt   = mean_r;
    rd_cnt_nxt = rd_cnt_r;
    acc_nxt    = acc_r;
    var_nxt    = var_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (store_ok) begin
            sum_nxt = sum_r + SumBits'(signed'(in_tdata[SampleBits-1:0]));
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            if ((store_ok ? cnt_r + 1'b1 : cnt_r) < CountBits'(2)) begin
              var_nxt   = '0;
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_MEAN;
            end
          end
        end
      end
      ST_MEAN: begin
        state_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (drsp.done) begin
          mean_nxt = sum_r[SumBits-1] ? -DiffBits'(drsp.quotient)
                                      : DiffBits'(drsp.quotient);
          rd_cnt_nxt = '0;
          acc_nxt    = '0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_cnt_r < cnt_r) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        if (sq_vld_r) begin
          acc_nxt = acc_r + AccBits'(sq_r);
        end
        if (rd_cnt_r == cnt_r && !rd_vld_r && !diff_vld_r && !sq_vld_r) begin
          state_nxt = ST_VAR;
        end
      end
      ST_VAR: begin
        state_nxt = ST_VWAIT;
      end
      ST_VWAIT: begin
        if (drsp.done) begin
          if (drsp.quotient > TotBits'({VarBits{1'b1}})) begin
            var_nxt = '1;
          end else begin
            var_nxt = VarBits'(drsp.quotient);
          end
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          sum_nxt   = '0;
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign diff_mag = diff_r[DiffBits-1] ? DiffBits'(-diff_r) : DiffBits'(diff_r);

  // Sequencer state registers and the scan pipeline: read, difference, square.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      sum_r      <= '0;
      cnt_r      <= '0;
      drop_r     <= 1'b0;
      rd_vld_r   <= 1'b0;
      diff_vld_r <= 1'b0;
      sq_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sum_r      <= sum_nxt;
      cnt_r      <= cnt_nxt;
      drop_r     <= drop_nxt;
      rd_vld_r   <= (state_r == ST_SCAN) && (rd_cnt_r < cnt_r);
      diff_vld_r <= rd_vld_r;
      sq_vld_r   <= diff_vld_r;
    end
    mean_r   <= mean_nxt;
    rd_cnt_r <= rd_cnt_nxt;
    acc_r    <= acc_nxt;
    var_r    <= var_nxt;
    diff_r   <= $signed({rd_data, 16'h0000}) - mean_r;
    sq_r     <= diff_mag * diff_mag;
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tlast  = 1'b0;
  assign out_tdata  = {5'b00000, drop_r, cnt_r[OutCountBits-1:0], var_r};

endmodule

### tb/tb_sample_variance_two_pass_top.sv
// Testbench for sample_variance_two_pass_top: it streams sets of samples and checks every
// variance beat against a behavioral two-pass predictor or a directed row's expected result.
// Depends on svar_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_sample_variance_two_pass_top;
  import svar_pkg::*;

  localparam logic [30:0] VarMax = 31'h7FFF_FFFF;
  localparam int WatchdogLimit = 20000;

  typedef struct {
    logic [30:0] variance;
    logic [10:0] sample_count;
    logic        overflow;
  } var_result_t;

  // One row of the directed table; typed rows carry their expected result.
  typedef struct {
    logic [15:0] sample;
    logic        last;
    logic        typed;
    var_result_t result;
  } vec_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;  // [15:0] sample
  logic        in_tlast;  // last
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata; // [30:0] variance, [41:31] sample_count, [42] overflow
  logic        out_tlast;

  // Predictor state for the open set.
  int          set_samples[$];
  longint      set_sum;
  logic        set_dropped;

  var_result_t pending_results[$];
  int          error_count;
  int          beats_in;
  int          results_seen;
  int          idle_cycles;
  logic        no_gaps;

  sample_variance_two_pass_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Unbiased variance of a closed set, in integer units of the squared sample, saturated.
  function automatic logic [30:0] set_variance(int vals[$], longint sum);
    longint      n;
    longint      mean_mag;
    longint      mean;
    longint      diff;
    logic [95:0] mag;
    logic [95:0] total;
    logic [95:0] quot;
    n = vals.size();
    if (n < 2) return '0;
    mean_mag = ((sum < 0) ? -sum : sum) * 65536 / n;
    mean = (sum < 0) ? -mean_mag : mean_mag;
    total = '0;
    foreach (vals[i]) begin
      diff = longint'(vals[i]) * 65536 - mean;
      mag = (diff < 0) ? 96'(-diff) : 96'(diff);
      total += mag * mag;
    end
    quot = (total >> 32) / 96'(n - 1);
    return (quot > 96'(VarMax)) ? VarMax : quot[30:0];
  endfunction

  // Folds one accepted beat into the open set; returns 1 with the result on tlast.
  function automatic bit accumulate_sample(logic [15:0] sample, logic last,
                                           output var_result_t res);
    if (set_samples.size() < MaxSamples) begin
      set_samples.push_back(int'($signed(sample)));
      set_sum += int'($signed(sample));
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return 0;
    res.variance = set_variance(set_samples, set_sum);
    res.sample_count = 11'(set_samples.size());
    res.overflow = set_dropped;
    set_samples.delete();
    set_sum = 0;
    set_dropped = 1'b0;
    return 1;
  endfunction

  // Mostly short gaps, now and then a long one; none during a burst stretch.
  function automatic int gap_length();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Sends one beat, waits for its acceptance and queues what it should produce.
  task automatic send_sample(input logic [15:0] sample, input logic last, input bit typed,
                             input var_result_t typed_res);
    int          gap;
    var_result_t res;
    gap = gap_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    beats_in++;
    if (accumulate_sample(sample, last, res))
      pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random sample: extremes, small values near zero, or anything.
  function automatic logic [15:0] random_sample(int spread);
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'h7FFF;
    if (r < 16) return 16'h8000;
    if (r < 16 + spread) return 16'($urandom_range(512) - 256);
    return 16'($urandom());
  endfunction

  // Result side: random backpressure.
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      @(posedge clk);
      if (gap_length() > 0) begin
        out_tready <= 1'b0;
        repeat (gap_length() + 1) @(posedge clk);
      end
    end
  end

  // Result check against the oldest expectation.
  always @(posedge clk) begin
    var_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("[%0t] result beat with nothing expected: %h", $realtime, out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[30:0] !== want.variance)
          report_mismatch("variance", out_tdata[30:0], want.variance);
        if (out_tdata[41:31] !== want.sample_count)
          report_mismatch("sample_count", out_tdata[41:31], want.sample_count);
        if (out_tdata[42] !== want.overflow)
          report_mismatch("overflow", out_tdata[42], want.overflow);
        if (out_tdata[47:43] !== 5'b0)
          report_mismatch("pad bits", out_tdata[47:43], 0);
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout after %0d cycles without a beat", WatchdogLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    vec_row_t    rows[$];
    var_result_t none;
    int          set_len;
    int          spread;
    int          drain;
    none = '{default: '0};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    set_sum = 0;
    set_dropped = 1'b0;
    error_count = 0;
    beats_in = 0;
    results_seen = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;

    // Singles and equal sets expect zero from the table; other sets go to the predictor.
    rows = '{
      '{16'h7FFF, 1'b1, 1'b1, '{31'd0, 11'd1, 1'b0}},
      '{16'h8000, 1'b1, 1'b1, '{31'd0, 11'd1, 1'b0}},
      '{16'h0000, 1'b1, 1'b1, '{31'd0, 11'd1, 1'b0}},
      '{16'h7FFF, 1'b0, 1'b0, none},
      '{16'h8000, 1'b1, 1'b0, none},
      '{16'h8000, 1'b0, 1'b0, none},
      '{16'h7FFF, 1'b1, 1'b0, none},
      '{16'h0064, 1'b0, 1'b0, none},
      '{16'h0064, 1'b1, 1'b1, '{31'd0, 11'd2, 1'b0}},
      '{16'h5555, 1'b0, 1'b0, none},
      '{16'hAAAA, 1'b0, 1'b0, none},
      '{16'hFFFF, 1'b0, 1'b0, none},
      '{16'h0001, 1'b1, 1'b0, none},
      '{16'h8000, 1'b0, 1'b0, none},
      '{16'h8000, 1'b0, 1'b0, none},
      '{16'h8000, 1'b1, 1'b1, '{31'd0, 11'd3, 1'b0}},
      '{16'h0100, 1'b0, 1'b0, none},
      '{16'hFF00, 1'b0, 1'b0, none},
      '{16'h0100, 1'b0, 1'b0, none},
      '{16'hFF00, 1'b1, 1'b0, none}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_sample(rows[i].sample, rows[i].last, rows[i].typed, rows[i].result);

    // Hold the sender until every result of the directed part is out.
    wait_drained();

    // Random sets, mostly short, with bursts that run without gaps.
    while (beats_in < 550) begin
      no_gaps = ($urandom_range(5) == 0);
      spread = $urandom_range(80);
      set_len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
      for (int k = 0; k < set_len; k++)
        send_sample(random_sample(spread), k == set_len - 1, 1'b0, none);
    end
    no_gaps = 1'b0;

    in_tvalid <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < 50000) begin
      @(posedge clk);
      drain++;
    end
    repeat (300) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      error_count++;
    end

    $display("Covered %0d sample beats and %0d variance results: single-sample sets,",
             beats_in, results_seen);
    $display("opposite extremes and random sets under input gaps and output stalls.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
design/svar_pkg.sv
design/svar_div.sv
design/svar_store.sv
design/sample_variance_two_pass_top.sv
tb/tb_sample_variance_two_pass_top.sv
